/* src/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, quiet while reset is held
`define FCT_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent assertion that also runs during reset
`define FCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/fct_pkg.sv */
// shared constants, codes and types of the frustum cull test block
// no dependencies
`default_nettype none

package fct_pkg;

    localparam int COORD_BITS  = 16;
    localparam int NUM_PLANES  = 6;
    localparam int SIDE_PLANES = 4;
    localparam int PLANE_W     = 64;
    localparam int FIELD_W     = 16;
    localparam int D_SHIFT     = 14;
    localparam int RAD_W       = COORD_BITS - 1;
    localparam int PROD_W      = COORD_BITS + FIELD_W;
    localparam int DTERM_W     = FIELD_W + D_SHIFT;
    localparam int DIST_W      = ((PROD_W > DTERM_W) ? PROD_W : DTERM_W) + 3;
    localparam int CFG_IDX_W   = $clog2(NUM_PLANES);

    // primitive kinds
    localparam logic [1:0] CMD_POINT  = 2'd0;
    localparam logic [1:0] CMD_SPHERE = 2'd1;
    localparam logic [1:0] CMD_BOX    = 2'd2;

    // verdict codes
    localparam logic [1:0] VERDICT_INSIDE    = 2'd0;
    localparam logic [1:0] VERDICT_INTERSECT = 2'd1;
    localparam logic [1:0] VERDICT_OUTSIDE   = 2'd2;

    typedef struct packed {
        logic [1:0]            command;
        logic                  light_mode;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [COORD_BITS-1:0] pos_z;
        logic [COORD_BITS-1:0] max_x;
        logic [COORD_BITS-1:0] max_y;
        logic [COORD_BITS-1:0] max_z;
        logic [RAD_W-1:0]      radius;
    } t_item;

    typedef struct packed {
        logic [1:0]       command;
        logic [RAD_W-1:0] radius;
    } t_cls;

    typedef struct packed {
        logic outside;
        logic isect;
    } t_flags;

endpackage

`default_nettype wire

/* src/fct_lane.sv */
// one plane lane: vertex pick, registered products, distance and classification
// depends on fct_pkg
`default_nettype none

module fct_lane import fct_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [PLANE_W-1:0] i_plane,
    input  t_item              i_item,
    input  t_cls               i_cls,
    output t_flags             o_flags
);

    logic signed [FIELD_W-1:0]    w_coef [3];
    logic signed [FIELD_W-1:0]    w_d;
    logic signed [COORD_BITS-1:0] w_lo [3];
    logic signed [COORD_BITS-1:0] w_hi [3];
    logic signed [COORD_BITS-1:0] w_pv [3];
    logic signed [COORD_BITS-1:0] w_nv [3];
    logic                         w_box;
    logic signed [PROD_W-1:0]     n_pp [3];
    logic signed [PROD_W-1:0]     n_pn [3];
    logic signed [PROD_W-1:0]     r_pp [3];
    logic signed [PROD_W-1:0]     r_pn [3];
    logic signed [FIELD_W-1:0]    r_d;
    logic signed [DIST_W-1:0]     w_dterm;
    logic signed [DIST_W-1:0]     w_dp;
    logic signed [DIST_W-1:0]     w_dn;
    logic signed [DIST_W-1:0]     w_rad;
    logic signed [DIST_W-1:0]     w_abs;

    assign w_coef[0] = $signed(i_plane[FIELD_W-1:0]);
    assign w_coef[1] = $signed(i_plane[2*FIELD_W-1:FIELD_W]);
    assign w_coef[2] = $signed(i_plane[3*FIELD_W-1:2*FIELD_W]);
    assign w_d       = $signed(i_plane[4*FIELD_W-1:3*FIELD_W]);

    assign w_lo[0] = $signed(i_item.pos_x);
    assign w_lo[1] = $signed(i_item.pos_y);
    assign w_lo[2] = $signed(i_item.pos_z);
    assign w_hi[0] = $signed(i_item.max_x);
    assign w_hi[1] = $signed(i_item.max_y);
    assign w_hi[2] = $signed(i_item.max_z);

    // codes two and three both run the box test
    assign w_box = (i_item.command != CMD_POINT) && (i_item.command != CMD_SPHERE);

    // p vertex takes max where the normal is non-negative, point and sphere use pos
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (w_box && !w_coef[k][FIELD_W-1]) begin
                w_pv[k] = w_hi[k];
                w_nv[k] = w_lo[k];
            end else begin
                w_pv[k] = w_lo[k];
                w_nv[k] = w_hi[k];
            end
            n_pp[k] = PROD_W'(w_coef[k]) * PROD_W'(w_pv[k]);
            n_pn[k] = PROD_W'(w_coef[k]) * PROD_W'(w_nv[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp <= n_pp;
            r_pn <= n_pn;
            r_d  <= w_d;
        end
    end

    // exact distances with 22 fraction bits
    assign w_dterm = DIST_W'(r_d) <<< D_SHIFT;
    assign w_dp    = DIST_W'(r_pp[0]) + DIST_W'(r_pp[1]) + DIST_W'(r_pp[2]) + w_dterm;
    assign w_dn    = DIST_W'(r_pn[0]) + DIST_W'(r_pn[1]) + DIST_W'(r_pn[2]) + w_dterm;
    assign w_rad   = $signed(DIST_W'(i_cls.radius) << D_SHIFT);
    assign w_abs   = w_dp[DIST_W-1] ? -w_dp : w_dp;

    always_comb begin
        o_flags = '0;
        unique case (i_cls.command)
            CMD_POINT: begin
                o_flags.outside = w_dp[DIST_W-1];
                o_flags.isect   = (w_dp == '0);
            end
            CMD_SPHERE: begin
                o_flags.outside = (w_dp < -w_rad);
                o_flags.isect   = (w_abs < w_rad);
            end
            default: begin
                o_flags.outside = w_dp[DIST_W-1];
                o_flags.isect   = w_dn[DIST_W-1];
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/frustum_cull_test_core.sv */
// frustum cull test: classifies a point, sphere or box against six planes
// depends on fct_pkg and fct_lane
// throughput: one word per cycle unless the output stalls; three register stages (input, products, verdict)
// reset: synchronous active low, clears all valid flags and the six plane registers to 0
`default_nettype none

module frustum_cull_test_core import fct_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    // input words
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_command,
    input  logic                         i_light_mode,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    input  logic signed [COORD_BITS-1:0] i_max_x,
    input  logic signed [COORD_BITS-1:0] i_max_y,
    input  logic signed [COORD_BITS-1:0] i_max_z,
    input  logic [RAD_W-1:0]             i_radius,

    // result words
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_verdict,

    // plane register writes
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [PLANE_W-1:0]           i_cfg_data
);

    // plane registers, right left bottom top near far
    logic [PLANE_W-1:0] r_plane [NUM_PLANES];

    // stage a: captured input word
    logic   r_a_valid;
    t_item  r_a_item;
    t_item  n_item;

    // stage b: products live inside the lanes, kind, light mode and radius ride alongside
    logic   r_b_valid;
    logic   r_b_light;
    t_cls   r_b_cls;

    // stage c: result register
    logic       r_out_valid;
    logic [1:0] r_verdict;
    logic [1:0] n_verdict;

    logic   w_en_a;
    logic   w_en_b;
    logic   w_en_c;
    t_flags w_flags [NUM_PLANES];
    logic   w_any_out;
    logic   w_any_isect;

    // writes are taken any time, out-of-range indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                r_plane[p] <= '0;
            end
        end else if (i_cfg_valid) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                if (i_cfg_index == CFG_IDX_W'(p)) begin
                    r_plane[p] <= i_cfg_data;
                end
            end
        end
    end

    // a stage moves when it is empty or the stage after it moves
    assign w_en_c     = !r_out_valid || !i_out_stall;
    assign w_en_b     = !r_b_valid || w_en_c;
    assign w_en_a     = !r_a_valid || w_en_b;
    assign o_in_stall = !w_en_a;

    always_comb begin
        n_item.command    = i_command;
        n_item.light_mode = i_light_mode;
        n_item.pos_x      = i_pos_x;
        n_item.pos_y      = i_pos_y;
        n_item.pos_z      = i_pos_z;
        n_item.max_x      = i_max_x;
        n_item.max_y      = i_max_y;
        n_item.max_z      = i_max_z;
        n_item.radius     = i_radius;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en_a) begin
                r_a_valid <= i_in_valid;
            end
            if (w_en_b) begin
                r_b_valid <= r_a_valid;
            end
            if (w_en_c) begin
                r_out_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a && i_in_valid) begin
            r_a_item <= n_item;
        end
        if (w_en_b) begin
            r_b_light       <= r_a_item.light_mode;
            r_b_cls.command <= r_a_item.command;
            r_b_cls.radius  <= r_a_item.radius;
        end
        if (w_en_c) begin
            r_verdict <= n_verdict;
        end
    end

    // one lane per plane, each with its own multipliers
    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_lane
        fct_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en_b),
            .i_plane (r_plane[g]),
            .i_item  (r_a_item),
            .i_cls   (r_b_cls),
            .o_flags (w_flags[g])
        );
    end

    // light mode drops near and far; outside wins over intersect
    always_comb begin
        w_any_out   = 1'b0;
        w_any_isect = 1'b0;
        for (int p = 0; p < NUM_PLANES; p++) begin
            if (p < SIDE_PLANES || !r_b_light) begin
                w_any_out   = w_any_out | w_flags[p].outside;
                w_any_isect = w_any_isect | w_flags[p].isect;
            end
        end
        if (w_any_out) begin
            n_verdict = VERDICT_OUTSIDE;
        end else if (w_any_isect) begin
            n_verdict = VERDICT_INTERSECT;
        end else begin
            n_verdict = VERDICT_INSIDE;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

endmodule

`default_nettype wire

/* src/fct_checker.sv */
// port level checks for frustum_cull_test_core, bound to the top level
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module fct_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [1:0] o_verdict
);

    // a stalled result word holds
    `FCT_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_verdict), "result word changed while stalled")

    // input only backs up when every stage is full behind a stalled output
    `FCT_ASSERT_RST(a_stall_cause, i_clk, i_rst_n, o_in_stall |-> o_out_valid && i_out_stall, "input stalled with room in the pipeline")

    // with a free output an accepted word moves through the product and verdict registers to the output
    `FCT_ASSERT_RST(a_latency, i_clk, i_rst_n, (i_in_valid && !o_in_stall) ##1 !i_out_stall ##1 !i_out_stall |=> o_out_valid, "accepted word did not reach the output")

    // reset empties the output
    `FCT_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind frustum_cull_test_core fct_checker u_fct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_verdict   (o_verdict)
);

`default_nettype wire

/* tb/sv/cull_scoreboard_pkg.sv */
// verdict predictor and scoreboard for the frustum cull test block
// depends on fct_pkg for widths, primitive kinds and verdict codes
`timescale 1ns / 100ps

package cull_scoreboard_pkg;
    import fct_pkg::*;

    // plane register indexes, in register order
    typedef enum logic [CFG_IDX_W-1:0] {
        PL_RIGHT, PL_LEFT, PL_BOTTOM, PL_TOP, PL_NEAR, PL_FAR
    } t_plane_idx;

    // the unused fourth kind decodes as a box
    localparam logic [1:0] CMD_BOX_ALT = 2'd3;

    class cull_scoreboard;
        logic [PLANE_W-1:0] planes [NUM_PLANES];
        logic [1:0]         pending_verdicts [$];
        int                 fails;
        int                 checked;
        int                 tally [3];

        function new();
            foreach (planes[i]) planes[i] = '0;
            foreach (tally[i]) tally[i] = 0;
            fails   = 0;
            checked = 0;
        endfunction

        // out-of-range indexes are dropped by the block
        function void set_plane(int unsigned idx, logic [PLANE_W-1:0] value);
            if (idx < NUM_PLANES) planes[idx] = value;
        endfunction

        function longint coef(logic [PLANE_W-1:0] p, int k);
            return longint'($signed(p[FIELD_W*k +: FIELD_W]));
        endfunction

        // exact signed distance, 22 fraction bits
        function longint distance(logic [PLANE_W-1:0] p, longint x, longint y, longint z);
            return coef(p, 0) * x + coef(p, 1) * y + coef(p, 2) * z
                   + coef(p, 3) * (longint'(1) << D_SHIFT);
        endfunction

        function logic [1:0] classify(t_item w);
            longint     lo [3];
            longint     hi [3];
            longint     pv [3];
            longint     nv [3];
            longint     rad;
            longint     d;
            longint     ad;
            int         count;
            logic [1:0] verdict;
            lo[0] = longint'($signed(w.pos_x));
            lo[1] = longint'($signed(w.pos_y));
            lo[2] = longint'($signed(w.pos_z));
            hi[0] = longint'($signed(w.max_x));
            hi[1] = longint'($signed(w.max_y));
            hi[2] = longint'($signed(w.max_z));
            rad     = longint'(w.radius) * (longint'(1) << D_SHIFT);
            count   = w.light_mode ? SIDE_PLANES : NUM_PLANES;
            verdict = VERDICT_INSIDE;
            for (int i = 0; i < count; i++) begin
                if (w.command == CMD_POINT) begin
                    d = distance(planes[i], lo[0], lo[1], lo[2]);
                    if (d < 0) begin
                        verdict = VERDICT_OUTSIDE;
                        break;
                    end
                    if (d == 0) verdict = VERDICT_INTERSECT;
                end else if (w.command == CMD_SPHERE) begin
                    d  = distance(planes[i], lo[0], lo[1], lo[2]);
                    ad = (d < 0) ? -d : d;
                    if (d < -rad) begin
                        verdict = VERDICT_OUTSIDE;
                        break;
                    end
                    if (ad < rad) verdict = VERDICT_INTERSECT;
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        pv[k] = (coef(planes[i], k) >= 0) ? hi[k] : lo[k];
                        nv[k] = (coef(planes[i], k) >= 0) ? lo[k] : hi[k];
                    end
                    if (distance(planes[i], pv[0], pv[1], pv[2]) < 0) begin
                        verdict = VERDICT_OUTSIDE;
                        break;
                    end
                    if (distance(planes[i], nv[0], nv[1], nv[2]) < 0)
                        verdict = VERDICT_INTERSECT;
                end
            end
            return verdict;
        endfunction

        function void note_word(t_item w);
            pending_verdicts.push_back(classify(w));
        endfunction

        function void check_word(logic [1:0] got);
            logic [1:0] exp_v;
            if (pending_verdicts.size() == 0) begin
                fails++;
                if (fails <= 10) $display("unexpected verdict %0d with nothing pending", got);
                return;
            end
            exp_v = pending_verdicts.pop_front();
            checked++;
            if (exp_v < 3) tally[exp_v]++;
            if (got !== exp_v) begin
                fails++;
                if (fails <= 10)
                    $display("verdict mismatch on word %0d: expected %0d, got %0d",
                             checked, exp_v, got);
            end
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction
    endclass

endpackage

/* tb/sv/tb_top.sv */
// top-level bench for frustum_cull_test_core: drives words and plane writes
// depends on fct_pkg, cull_scoreboard_pkg and the block itself
`timescale 1ns / 100ps

module tb_top;
    import fct_pkg::*;
    import cull_scoreboard_pkg::*;

    localparam int RANDOM_WORDS = 1100;
    localparam int TOTAL_WORDS  = RANDOM_WORDS + 22;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    // 1.0 and -1.0 in Q1.14
    localparam logic [FIELD_W-1:0] Q14_ONE     = 16'h4000;
    localparam logic [FIELD_W-1:0] Q14_NEG_ONE = 16'hC000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [1:0]            i_command;
    logic                  i_light_mode;
    logic [COORD_BITS-1:0] i_pos_x;
    logic [COORD_BITS-1:0] i_pos_y;
    logic [COORD_BITS-1:0] i_pos_z;
    logic [COORD_BITS-1:0] i_max_x;
    logic [COORD_BITS-1:0] i_max_y;
    logic [COORD_BITS-1:0] i_max_z;
    logic [RAD_W-1:0]      i_radius;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [1:0]            o_verdict;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [PLANE_W-1:0]    i_cfg_data;

    cull_scoreboard sb;

    // idle percentages for both sides, stepped by how many words went in
    int tx_idle_pct;
    int rx_idle_pct;
    int words_sent;
    int plane_writes;
    int settings_used;
    int cycle_count = 0;

    // the region random coordinates cluster around, and the boundary value
    int coord_span;
    int coord_bound;

    frustum_cull_test_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_light_mode (i_light_mode),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_max_x      (i_max_x),
        .i_max_y      (i_max_y),
        .i_max_z      (i_max_z),
        .i_radius     (i_radius),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_verdict    (o_verdict),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts pending", cycle_count,
                     sb.pending());
            $display("Verification failed");
            $finish;
        end
    end

    // receiver back-pressure, changed only on the falling edge
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // result monitor: every accepted verdict goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_word(o_verdict);
    end

    function automatic logic [PLANE_W-1:0] pack_plane(logic [FIELD_W-1:0] a,
                                                     logic [FIELD_W-1:0] b,
                                                     logic [FIELD_W-1:0] c,
                                                     logic [FIELD_W-1:0] d);
        return {d, c, b, a};
    endfunction

    // idling schedule: slow receiver, then slow sender, then full rate
    function automatic void update_idling();
        if (words_sent < TOTAL_WORDS / 3) begin
            tx_idle_pct = 19;
            rx_idle_pct = 74;
        end else if (words_sent < 2 * TOTAL_WORDS / 3) begin
            tx_idle_pct = 74;
            rx_idle_pct = 19;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endfunction

    // mostly near the planes, sometimes exactly on one, sometimes anywhere
    function automatic logic [COORD_BITS-1:0] rand_coord();
        int sel;
        sel = $urandom_range(15);
        if (sel == 0) return COORD_BITS'($urandom);
        if (sel == 1) return $urandom_range(1) ? 16'h7FFF : 16'h8000;
        if (sel <= 3) return $urandom_range(1) ? COORD_BITS'(coord_bound)
                                                : COORD_BITS'(-coord_bound);
        return COORD_BITS'(int'($urandom_range(2 * coord_span)) - coord_span);
    endfunction

    // box maximum a little above the minimum, saturated at the top of range
    function automatic logic [COORD_BITS-1:0] box_max(logic [COORD_BITS-1:0] lo);
        int v;
        v = int'($signed(lo)) + int'($urandom_range(coord_span / 2));
        if (v > 32767) v = 32767;
        return COORD_BITS'(v);
    endfunction

    function automatic t_item rand_item();
        t_item w;
        int    sel;
        sel = $urandom_range(11);
        if (sel < 4)       w.command = CMD_POINT;
        else if (sel < 8)  w.command = CMD_SPHERE;
        else if (sel < 11) w.command = CMD_BOX;
        else               w.command = CMD_BOX_ALT;
        w.light_mode = 1'($urandom_range(1));
        w.pos_x = rand_coord();
        w.pos_y = rand_coord();
        w.pos_z = rand_coord();
        // a few boxes get unrelated corners, often inverted
        if ($urandom_range(7) == 0) begin
            w.max_x = rand_coord();
            w.max_y = rand_coord();
            w.max_z = rand_coord();
        end else begin
            w.max_x = box_max(w.pos_x);
            w.max_y = box_max(w.pos_y);
            w.max_z = box_max(w.pos_z);
        end
        case ($urandom_range(9))
            0:       w.radius = RAD_W'($urandom);
            1:       w.radius = $urandom_range(1) ? '1 : '0;
            default: w.radius = RAD_W'($urandom_range(coord_span / 2));
        endcase
        return w;
    endfunction

    // one input word; the valid stays high into the next call when no gap is drawn
    task automatic send_word(input t_item w);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_command    <= w.command;
        i_light_mode <= w.light_mode;
        i_pos_x      <= w.pos_x;
        i_pos_y      <= w.pos_y;
        i_pos_z      <= w.pos_z;
        i_max_x      <= w.max_x;
        i_max_y      <= w.max_y;
        i_max_z      <= w.max_z;
        i_radius     <= w.radius;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(w);
        words_sent++;
        update_idling();
    endtask

    // directed word builder
    task automatic send_fields(input logic [1:0] cmd, input logic light,
                               input logic [COORD_BITS-1:0] px, py, pz, mx, my, mz,
                               input logic [RAD_W-1:0] rad);
        t_item w;
        w = '{command: cmd, light_mode: light, pos_x: px, pos_y: py, pos_z: pz,
              max_x: mx, max_y: my, max_z: mz, radius: rad};
        send_word(w);
    endtask

    // drop valid and let the pipe empty before touching the plane registers
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_plane(input int unsigned idx, input logic [PLANE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_IDX_W'(idx);
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_plane(idx, value);
        plane_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_planes(input logic [PLANE_W-1:0] pl [NUM_PLANES]);
        for (int i = 0; i < NUM_PLANES; i++) write_plane(i, pl[i]);
        settings_used++;
    endtask

    // axis-aligned view box: |x|,|y| <= half, |z| <= half_z
    task automatic load_axis_box(input int half, input int half_z);
        logic [PLANE_W-1:0] pl [NUM_PLANES];
        pl[PL_RIGHT]  = pack_plane(Q14_NEG_ONE, '0, '0, FIELD_W'(half));
        pl[PL_LEFT]   = pack_plane(Q14_ONE, '0, '0, FIELD_W'(half));
        pl[PL_BOTTOM] = pack_plane('0, Q14_ONE, '0, FIELD_W'(half));
        pl[PL_TOP]    = pack_plane('0, Q14_NEG_ONE, '0, FIELD_W'(half));
        pl[PL_NEAR]   = pack_plane('0, '0, Q14_ONE, FIELD_W'(half_z));
        pl[PL_FAR]    = pack_plane('0, '0, Q14_NEG_ONE, FIELD_W'(half_z));
        load_planes(pl);
        coord_span  = (half * 3) / 2;
        coord_bound = half;
    endtask

    initial begin : stimulus
        logic [PLANE_W-1:0] pl [NUM_PLANES];
        int                 random_sent;
        int                 phase;
        int                 extreme_idx;
        int                 half;
        int                 n;

        // every input known from time zero, reset held and then released on a falling edge
        sb            = new();
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_command     = CMD_POINT;
        i_light_mode  = 1'b0;
        i_pos_x       = '0;
        i_pos_y       = '0;
        i_pos_z       = '0;
        i_max_x       = '0;
        i_max_y       = '0;
        i_max_z       = '0;
        i_radius      = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        words_sent    = 0;
        plane_writes  = 0;
        settings_used = 1;
        random_sent   = 0;
        phase         = 0;
        extreme_idx   = 0;
        update_idling();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all planes zero out of reset: every distance is exactly zero
        send_fields(CMD_POINT, 1'b0, 16'h0000, 16'h0000, 16'h0000, '0, '0, '0, '0);
        send_fields(CMD_SPHERE, 1'b0, 16'h0100, 16'h0000, 16'h0000, '0, '0, '0, 15'd1);
        send_fields(CMD_SPHERE, 1'b0, 16'h0100, 16'h0000, 16'h0000, '0, '0, '0, 15'd0);
        send_fields(CMD_BOX, 1'b0, 16'h8000, 16'h8000, 16'h8000,
                    16'h7FFF, 16'h7FFF, 16'h7FFF, '0);
        send_fields(CMD_BOX_ALT, 1'b1, 16'h0010, 16'h0010, 16'h0010,
                    16'h0020, 16'h0020, 16'h0020, '0);

        // 16.0 box on x and y, 8.0 on z
        settle();
        load_axis_box(16'h1000, 16'h0800);

        // points: centre, exactly on the right plane, just past it
        send_fields(CMD_POINT, 1'b0, 16'h0000, 16'h0000, 16'h0000, '0, '0, '0, '0);
        send_fields(CMD_POINT, 1'b0, 16'h1000, 16'h0000, 16'h0000, '0, '0, '0, '0);
        send_fields(CMD_POINT, 1'b0, 16'h1001, 16'h0000, 16'h0000, '0, '0, '0, '0);
        // beyond the far plane: outside with all six, inside with the side four
        send_fields(CMD_POINT, 1'b0, 16'h0000, 16'h0000, 16'h0900, '0, '0, '0, '0);
        send_fields(CMD_POINT, 1'b1, 16'h0000, 16'h0000, 16'h0900, '0, '0, '0, '0);
        // spheres: touching from outside, just short, and straddling all planes
        send_fields(CMD_SPHERE, 1'b0, 16'h1100, 16'h0000, 16'h0000, '0, '0, '0, 15'h0100);
        send_fields(CMD_SPHERE, 1'b0, 16'h1100, 16'h0000, 16'h0000, '0, '0, '0, 15'h00FF);
        send_fields(CMD_SPHERE, 1'b0, 16'h0000, 16'h0000, 16'h0000, '0, '0, '0, 15'h2000);
        // boxes: inside, across the right plane, fully beyond it, inverted
        send_fields(CMD_BOX, 1'b0, 16'hFF00, 16'hFF00, 16'hFF00,
                    16'h0100, 16'h0100, 16'h0100, '0);
        send_fields(CMD_BOX, 1'b0, 16'h0F00, 16'h0000, 16'h0000,
                    16'h1100, 16'h0100, 16'h0100, '0);
        send_fields(CMD_BOX, 1'b0, 16'h1100, 16'h0000, 16'h0000,
                    16'h1200, 16'h0100, 16'h0100, '0);
        send_fields(CMD_BOX, 1'b0, 16'h0100, 16'h0100, 16'h0100,
                    16'hFF00, 16'hFF00, 16'hFF00, '0);
        // field extremes
        send_fields(CMD_POINT, 1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, '0, '0, '0, '0);
        send_fields(CMD_POINT, 1'b1, 16'h8000, 16'h8000, 16'h8000, '0, '0, '0, '0);
        send_fields(CMD_SPHERE, 1'b0, 16'h8000, 16'h8000, 16'h8000,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF);
        send_fields(CMD_BOX, 1'b0, 16'h8000, 16'h8000, 16'h8000,
                    16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h7FFF);
        send_fields(CMD_BOX_ALT, 1'b0, 16'h0F00, 16'h0000, 16'h0000,
                    16'h1100, 16'h0100, 16'h0100, 15'h7FFF);

        // random phases, each under a fresh set of planes
        while (random_sent < RANDOM_WORDS) begin
            settle();
            case (phase % 6)
                0, 3: begin
                    load_axis_box($urandom_range(16'h0100, 16'h3000),
                                  $urandom_range(16'h0100, 16'h3000));
                end
                1: begin
                    // oblique planes, origin always on the inner side
                    half = $urandom_range(16'h0100, 16'h3000);
                    for (int i = 0; i < NUM_PLANES; i++)
                        pl[i] = pack_plane(FIELD_W'($urandom_range(16'h8000) - 16'h4000),
                                           FIELD_W'($urandom_range(16'h8000) - 16'h4000),
                                           FIELD_W'($urandom_range(16'h8000) - 16'h4000),
                                           FIELD_W'($urandom_range(half)));
                    load_planes(pl);
                    coord_span  = 2 * half;
                    coord_bound = half;
                end
                2, 5: begin
                    // register extremes, same on every plane
                    for (int i = 0; i < NUM_PLANES; i++) begin
                        case (extreme_idx % 5)
                            0:       pl[i] = '1;
                            1:       pl[i] = pack_plane(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
                            2:       pl[i] = pack_plane(16'h8000, 16'h8000, 16'h8000, 16'h8000);
                            3:       pl[i] = pack_plane(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
                            default: pl[i] = '0;
                        endcase
                    end
                    extreme_idx++;
                    load_planes(pl);
                    coord_span  = 16'h7FFF;
                    coord_bound = 16'h7FFF;
                end
                default: begin
                    for (int i = 0; i < NUM_PLANES; i++) pl[i] = {$urandom, $urandom};
                    load_planes(pl);
                    coord_span  = 16'h7FFF;
                    coord_bound = $urandom_range(16'h7FFF);
                end
            endcase
            // indexes past the last plane must leave the registers alone
            if (phase == 0) begin
                write_plane(NUM_PLANES, {$urandom, $urandom});
                write_plane(NUM_PLANES + 1, {$urandom, $urandom});
            end
            n = $urandom_range(50, 110);
            repeat (n) begin
                if (random_sent < RANDOM_WORDS) begin
                    send_word(rand_item());
                    random_sent++;
                end
            end
            phase++;
        end

        // drain and let any stray word show up
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d words classified: %0d inside, %0d intersect, %0d outside",
                 sb.checked, sb.tally[VERDICT_INSIDE], sb.tally[VERDICT_INTERSECT],
                 sb.tally[VERDICT_OUTSIDE]);
        $display("%0d plane settings, %0d register writes, %0d mismatches",
                 settings_used, plane_writes, sb.fails);
        if (sb.fails == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
